[hw/rtl/assert_macros.svh]
// assertion macros used by the rtl parser module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequence holds in the same cycle as the trigger
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the trigger
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/whp_pkg.sv]
// types and constants of the wav header parser
package whp_pkg;

    // little-endian chunk tags
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
    localparam logic [31:0] FMT_PCM        = 32'd1;

    // result status codes
    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_PREMATURE = 4'd1,
        ST_NO_RIFF   = 4'd2,
        ST_NO_WAVE   = 4'd3,
        ST_NO_FMT    = 4'd4,
        ST_FMT_SIZE  = 4'd5,
        ST_NOT_PCM   = 4'd6,
        ST_NO_DATA   = 4'd7,
        ST_EXTRA     = 4'd8
    } t_status;

    // parse phases, one-hot
    typedef enum logic [17:0] {
        PH_RIFF   = 18'h00001,
        PH_RSIZE  = 18'h00002,
        PH_WAVE   = 18'h00004,
        PH_OPT    = 18'h00008,
        PH_JSIZE  = 18'h00010,
        PH_JSKIP  = 18'h00020,
        PH_FMT    = 18'h00040,
        PH_FSIZE  = 18'h00080,
        PH_FORMAT = 18'h00100,
        PH_CHAN   = 18'h00200,
        PH_RATE   = 18'h00400,
        PH_BRATE  = 18'h00800,
        PH_ALIGN  = 18'h01000,
        PH_BITS   = 18'h02000,
        PH_DTAG   = 18'h04000,
        PH_DSIZE  = 18'h08000,
        PH_DATA   = 18'h10000,
        PH_DROP   = 18'h20000
    } t_phase;

    // one file byte
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_word;

    // one parse result
    typedef struct packed {
        t_status     status;
        logic [15:0] channel_count;
        logic [31:0] samp_rate;
        logic [31:0] byte_rate;
        logic [15:0] sample_bits;
        logic [31:0] payload_size;
        logic [32:0] payload_offset;
    } t_result;

endpackage

[hw/rtl/whp_in_reg.sv]
// input register that holds one file byte until the parser takes it
module whp_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  whp_pkg::t_in_word i_word,
    input  logic            i_advance,
    output logic            o_valid,
    output whp_pkg::t_in_word o_word
);

    logic              r_valid;
    logic              n_valid;
    whp_pkg::t_in_word r_word;
    logic              accept;

    // hold off the sender while a word waits and the parser cannot move
    assign o_in_stall = r_valid && !i_advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload loads only on accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

[hw/rtl/whp_parser.sv]
// header parse state and per-byte next-state logic
`include "assert_macros.svh"

module whp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output logic             o_res_valid,
    output whp_pkg::t_result o_res
);

    whp_pkg::t_phase r_phase, n_phase;
    logic [32:0]     r_field_count, n_field_count;
    logic [31:0]     r_tag, n_tag;
    logic [15:0]     r_channels, n_channels;
    logic [31:0]     r_rate, n_rate;
    logic [31:0]     r_byte_rate, n_byte_rate;
    logic [15:0]     r_bits, n_bits;
    logic [31:0]     r_size, n_size;
    logic [32:0]     r_offset, n_offset;
    logic [32:0]     r_data_count, n_data_count;

    logic [31:0]       gathered;
    logic              wide_field;
    logic              field_done;
    logic              err;
    logic [32:0]       pad;
    whp_pkg::t_status  status;

    // byte placed into the field, little-endian
    assign gathered = r_tag | ({24'd0, i_byte} << {r_field_count[1:0], 3'b000});

    // two-byte fields are format, channels, block align and bits
    assign wide_field = !(r_phase == whp_pkg::PH_FORMAT || r_phase == whp_pkg::PH_CHAN ||
                          r_phase == whp_pkg::PH_ALIGN  || r_phase == whp_pkg::PH_BITS);
    assign field_done = wide_field ? (r_field_count[1:0] == 2'd3)
                                   : (r_field_count[1:0] == 2'd1);

    // junk size rounded up to even, kept at 33 bits
    assign pad = {1'b0, gathered} + {32'd0, gathered[0]};

    always_comb begin
        n_phase       = r_phase;
        n_field_count = r_field_count;
        n_tag         = r_tag;
        n_channels    = r_channels;
        n_rate        = r_rate;
        n_byte_rate   = r_byte_rate;
        n_bits        = r_bits;
        n_size        = r_size;
        n_offset      = r_offset;
        n_data_count  = r_data_count;
        err           = 1'b0;
        status        = whp_pkg::ST_OK;
        o_res_valid   = 1'b0;
        o_res         = '0;

        if (i_take) begin
            unique case (r_phase)
                whp_pkg::PH_DROP: begin
                end
                whp_pkg::PH_DATA: begin
                    n_data_count = r_data_count + 33'd1;
                    if (n_data_count > {1'b0, r_size}) begin
                        err    = 1'b1;
                        status = whp_pkg::ST_EXTRA;
                    end
                end
                whp_pkg::PH_JSKIP: begin
                    n_offset = r_offset + 33'd1;
                    if (r_field_count != 33'd0) begin
                        n_field_count = r_field_count - 33'd1;
                    end
                    if (n_field_count == 33'd0) begin
                        n_phase = whp_pkg::PH_FMT;
                        n_tag   = '0;
                    end
                end
                default: begin
                    n_offset = r_offset + 33'd1;
                    if (!field_done) begin
                        n_tag         = gathered;
                        n_field_count = r_field_count + 33'd1;
                    end else begin
                        n_tag         = '0;
                        n_field_count = '0;
                        // judge the complete field
                        unique case (r_phase)
                            whp_pkg::PH_RIFF: begin
                                if (gathered != whp_pkg::TAG_RIFF) begin
                                    err    = 1'b1;
                                    status = whp_pkg::ST_NO_RIFF;
                                end else begin
                                    n_phase = whp_pkg::PH_RSIZE;
                                end
                            end
                            whp_pkg::PH_RSIZE: n_phase = whp_pkg::PH_WAVE;
                            whp_pkg::PH_WAVE: begin
                                if (gathered != whp_pkg::TAG_WAVE) begin
                                    err    = 1'b1;
                                    status = whp_pkg::ST_NO_WAVE;
                                end else begin
                                    n_phase = whp_pkg::PH_OPT;
                                end
                            end
                            whp_pkg::PH_OPT: begin
                                if (gathered == whp_pkg::TAG_JUNK) begin
                                    n_phase = whp_pkg::PH_JSIZE;
                                end else if (gathered == whp_pkg::TAG_FMT) begin
                                    n_phase = whp_pkg::PH_FSIZE;
                                end else begin
                                    err    = 1'b1;
                                    status = whp_pkg::ST_NO_FMT;
                                end
                            end
                            whp_pkg::PH_JSIZE: begin
                                if (pad == 33'd0) begin
                                    n_phase = whp_pkg::PH_FMT;
                                end else begin
                                    n_phase       = whp_pkg::PH_JSKIP;
                                    n_field_count = pad;
                                end
                            end
                            whp_pkg::PH_FMT: begin
                                if (gathered != whp_pkg::TAG_FMT) begin
                                    err    = 1'b1;
                                    status = whp_pkg::ST_NO_FMT;
                                end else begin
                                    n_phase = whp_pkg::PH_FSIZE;
                                end
                            end
                            whp_pkg::PH_FSIZE: begin
                                if (gathered != whp_pkg::FMT_CHUNK_SIZE) begin
                                    err    = 1'b1;
                                    status = whp_pkg::ST_FMT_SIZE;
                                end else begin
                                    n_phase = whp_pkg::PH_FORMAT;
                                end
                            end
                            whp_pkg::PH_FORMAT: begin
                                if (gathered != whp_pkg::FMT_PCM) begin
                                    err    = 1'b1;
                                    status = whp_pkg::ST_NOT_PCM;
                                end else begin
                                    n_phase = whp_pkg::PH_CHAN;
                                end
                            end
                            whp_pkg::PH_CHAN: begin
                                n_channels = gathered[15:0];
                                n_phase    = whp_pkg::PH_RATE;
                            end
                            whp_pkg::PH_RATE: begin
                                n_rate  = gathered;
                                n_phase = whp_pkg::PH_BRATE;
                            end
                            whp_pkg::PH_BRATE: begin
                                n_byte_rate = gathered;
                                n_phase     = whp_pkg::PH_ALIGN;
                            end
                            whp_pkg::PH_ALIGN: n_phase = whp_pkg::PH_BITS;
                            whp_pkg::PH_BITS: begin
                                n_bits  = gathered[15:0];
                                n_phase = whp_pkg::PH_DTAG;
                            end
                            whp_pkg::PH_DTAG: begin
                                if (gathered != whp_pkg::TAG_DATA) begin
                                    err    = 1'b1;
                                    status = whp_pkg::ST_NO_DATA;
                                end else begin
                                    n_phase = whp_pkg::PH_DSIZE;
                                end
                            end
                            whp_pkg::PH_DSIZE: begin
                                n_size       = gathered;
                                n_phase      = whp_pkg::PH_DATA;
                                n_data_count = '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            endcase

            // result on an error or at end of file: ok only when all declared data bytes are in
            if (r_phase != whp_pkg::PH_DROP && (err || i_last)) begin
                if (!err) begin
                    if (n_phase == whp_pkg::PH_DATA && n_data_count == {1'b0, n_size}) begin
                        status = whp_pkg::ST_OK;
                    end else begin
                        status = whp_pkg::ST_PREMATURE;
                    end
                end
                o_res_valid  = 1'b1;
                o_res.status = status;
                if (status == whp_pkg::ST_OK) begin
                    o_res.channel_count  = n_channels;
                    o_res.samp_rate      = n_rate;
                    o_res.byte_rate      = n_byte_rate;
                    o_res.sample_bits    = n_bits;
                    o_res.payload_size   = n_size;
                    o_res.payload_offset = n_offset;
                end
            end

            // last byte restarts the parse, an earlier error drops the rest
            if (i_last) begin
                n_phase       = whp_pkg::PH_RIFF;
                n_field_count = '0;
                n_tag         = '0;
                n_channels    = '0;
                n_rate        = '0;
                n_byte_rate   = '0;
                n_bits        = '0;
                n_size        = '0;
                n_offset      = '0;
                n_data_count  = '0;
            end else if (o_res_valid) begin
                n_phase = whp_pkg::PH_DROP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= whp_pkg::PH_RIFF;
            r_field_count <= '0;
            r_tag         <= '0;
            r_channels    <= '0;
            r_rate        <= '0;
            r_byte_rate   <= '0;
            r_bits        <= '0;
            r_size        <= '0;
            r_offset      <= '0;
            r_data_count  <= '0;
        end else begin
            r_phase       <= n_phase;
            r_field_count <= n_field_count;
            r_tag         <= n_tag;
            r_channels    <= n_channels;
            r_rate        <= n_rate;
            r_byte_rate   <= n_byte_rate;
            r_bits        <= n_bits;
            r_size        <= n_size;
            r_offset      <= n_offset;
            r_data_count  <= n_data_count;
        end
    end

    // data count never passes the declared size while still in data
    `ASSERT_IMPLY(a_data_in_range, r_phase == whp_pkg::PH_DATA,
        r_data_count <= {1'b0, r_size}, "data count beyond declared size")

    // byte index inside a header field stays below four
    `ASSERT_IMPLY(a_field_index, r_phase != whp_pkg::PH_JSKIP,
        r_field_count[32:2] == 31'd0, "field byte index out of range")

    // a result before the last byte leaves the parser dropping bytes
    `ASSERT_NEXT(a_drop_after_err, i_take && o_res_valid && !i_last,
        r_phase == whp_pkg::PH_DROP, "parser not dropping after error")

    // the last byte always restarts from the riff tag
    `ASSERT_NEXT(a_restart, i_take && i_last,
        r_phase == whp_pkg::PH_RIFF && r_offset == 33'd0, "parser not restarted")

endmodule

[hw/rtl/wav_header_parser_unit.sv]
// wav header parser: checks a riff/wave pcm header and reports its fields
//
// Input channel: one file byte per word (i_byte_value) with i_last_byte set
// on the final byte of the file, moved by i_in_valid / o_in_stall.
// Output channel: at most one result word per file (o_status and the fmt and
// data fields), moved by o_out_valid / i_out_stall. A result is given when the
// first header or data error is found, or on the last byte; after an error
// the remaining bytes up to the last one are taken and dropped. Fields other
// than status read zero unless status is ok.
// Throughput: one byte per cycle while a valid result is not held by
// i_out_stall; each byte costs a single phase and counter update between the
// input register and the result register.
// Stall: a valid result holds in the result register while i_out_stall is
// high; one more byte waits in the input register, after which o_in_stall is
// raised.
// Reset (synchronous, active low): both channels empty, parse restarts at the
// riff tag. The last byte of a file also restarts the parse.
module wav_header_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_status,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_samp_rate,
    output logic [31:0] o_byte_rate,
    output logic [15:0] o_sample_bits,
    output logic [31:0] o_payload_size,
    output logic [32:0] o_payload_offset
);

    whp_pkg::t_in_word in_word;
    whp_pkg::t_in_word held_word;
    whp_pkg::t_result  res;
    whp_pkg::t_result  r_out;
    logic              held_valid;
    logic              advance;
    logic              take;
    logic              res_valid;
    logic              r_out_valid;

    // the parser moves whenever the result register is free or being emptied
    assign advance = !r_out_valid || !i_out_stall;
    assign take    = held_valid && advance;

    assign in_word.byte_value = i_byte_value;
    assign in_word.last_byte  = i_last_byte;

    whp_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_word     (in_word),
        .i_advance  (advance),
        .o_valid    (held_valid),
        .o_word     (held_word)
    );

    whp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (held_word.byte_value),
        .i_last      (held_word.last_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_channel_count  = r_out.channel_count;
    assign o_samp_rate      = r_out.samp_rate;
    assign o_byte_rate      = r_out.byte_rate;
    assign o_sample_bits    = r_out.sample_bits;
    assign o_payload_size   = r_out.payload_size;
    assign o_payload_offset = r_out.payload_offset;

endmodule

[dv/tb.sv]
// testbench for the wav header parser: random and directed files checked word by word
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_byte_value;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [3:0]  o_status;
    logic [15:0] o_channel_count;
    logic [31:0] o_samp_rate;
    logic [31:0] o_byte_rate;
    logic [15:0] o_sample_bits;
    logic [31:0] o_payload_size;
    logic [32:0] o_payload_offset;

    wav_header_parser_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_byte_value     (i_byte_value),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_channel_count  (o_channel_count),
        .o_samp_rate      (o_samp_rate),
        .o_byte_rate      (o_byte_rate),
        .o_sample_bits    (o_sample_bits),
        .o_payload_size   (o_payload_size),
        .o_payload_offset (o_payload_offset)
    );

    // tracks the parse of the byte stream and holds the reports still owed
    class header_scoreboard;
        whp_pkg::t_phase  phase;
        logic [32:0]      field_count;
        logic [31:0]      tag_shift;
        logic [15:0]      channels;
        logic [31:0]      rate;
        logic [31:0]      byte_rate;
        logic [15:0]      bits;
        logic [31:0]      decl_size;
        logic [32:0]      header_bytes;
        logic [32:0]      data_bytes;
        whp_pkg::t_result pending_reports[$];
        int               errors;

        function new();
            restart();
            errors = 0;
        endfunction

        // parse state back to the riff tag
        function void restart();
            phase = whp_pkg::PH_RIFF;
            field_count = '0;
            tag_shift = '0;
            channels = '0;
            rate = '0;
            byte_rate = '0;
            bits = '0;
            decl_size = '0;
            header_bytes = '0;
            data_bytes = '0;
        endfunction

        // one accepted file byte; queues a report when one is due
        function void take_byte(logic [7:0] b, logic last);
            whp_pkg::t_status st;
            logic [31:0]      v;
            logic [32:0]      pad;
            int               field_len;
            whp_pkg::t_result r;
            if (phase == whp_pkg::PH_DROP) begin
                if (last) restart();
                return;
            end
            st = whp_pkg::ST_OK;
            if (phase == whp_pkg::PH_DATA) begin
                data_bytes++;
                if (data_bytes > {1'b0, decl_size}) st = whp_pkg::ST_EXTRA;
            end else begin
                header_bytes++;
                if (phase == whp_pkg::PH_JSKIP) begin
                    // junk body, padded length counted down
                    if (field_count != 0) field_count--;
                    if (field_count == 0) phase = whp_pkg::PH_FMT;
                end else begin
                    field_len = (phase inside {whp_pkg::PH_FORMAT, whp_pkg::PH_CHAN,
                                               whp_pkg::PH_ALIGN, whp_pkg::PH_BITS}) ? 2 : 4;
                    tag_shift |= {24'd0, b} << (8 * field_count[1:0]);
                    field_count++;
                    if (field_count >= field_len) begin
                        v = tag_shift;
                        tag_shift = '0;
                        field_count = '0;
                        case (phase)
                            whp_pkg::PH_RIFF: begin
                                if (v != whp_pkg::TAG_RIFF) st = whp_pkg::ST_NO_RIFF;
                                else phase = whp_pkg::PH_RSIZE;
                            end
                            whp_pkg::PH_RSIZE: phase = whp_pkg::PH_WAVE;
                            whp_pkg::PH_WAVE: begin
                                if (v != whp_pkg::TAG_WAVE) st = whp_pkg::ST_NO_WAVE;
                                else phase = whp_pkg::PH_OPT;
                            end
                            whp_pkg::PH_OPT: begin
                                if (v == whp_pkg::TAG_JUNK) phase = whp_pkg::PH_JSIZE;
                                else if (v == whp_pkg::TAG_FMT) phase = whp_pkg::PH_FSIZE;
                                else st = whp_pkg::ST_NO_FMT;
                            end
                            whp_pkg::PH_JSIZE: begin
                                // pad to even, no 32-bit wrap
                                pad = {1'b0, v} + v[0];
                                if (pad == 0) begin
                                    phase = whp_pkg::PH_FMT;
                                end else begin
                                    phase = whp_pkg::PH_JSKIP;
                                    field_count = pad;
                                end
                            end
                            whp_pkg::PH_FMT: begin
                                if (v != whp_pkg::TAG_FMT) st = whp_pkg::ST_NO_FMT;
                                else phase = whp_pkg::PH_FSIZE;
                            end
                            whp_pkg::PH_FSIZE: begin
                                if (v != whp_pkg::FMT_CHUNK_SIZE) st = whp_pkg::ST_FMT_SIZE;
                                else phase = whp_pkg::PH_FORMAT;
                            end
                            whp_pkg::PH_FORMAT: begin
                                if (v != whp_pkg::FMT_PCM) st = whp_pkg::ST_NOT_PCM;
                                else phase = whp_pkg::PH_CHAN;
                            end
                            whp_pkg::PH_CHAN: begin
                                channels = v[15:0];
                                phase = whp_pkg::PH_RATE;
                            end
                            whp_pkg::PH_RATE: begin
                                rate = v;
                                phase = whp_pkg::PH_BRATE;
                            end
                            whp_pkg::PH_BRATE: begin
                                byte_rate = v;
                                phase = whp_pkg::PH_ALIGN;
                            end
                            whp_pkg::PH_ALIGN: phase = whp_pkg::PH_BITS;
                            whp_pkg::PH_BITS: begin
                                bits = v[15:0];
                                phase = whp_pkg::PH_DTAG;
                            end
                            whp_pkg::PH_DTAG: begin
                                if (v != whp_pkg::TAG_DATA) st = whp_pkg::ST_NO_DATA;
                                else phase = whp_pkg::PH_DSIZE;
                            end
                            whp_pkg::PH_DSIZE: begin
                                decl_size = v;
                                data_bytes = '0;
                                phase = whp_pkg::PH_DATA;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            if (st == whp_pkg::ST_OK && !last) return;
            // a last byte short of the declared data is an early end
            if (st == whp_pkg::ST_OK &&
                !(phase == whp_pkg::PH_DATA && data_bytes == {1'b0, decl_size}))
                st = whp_pkg::ST_PREMATURE;
            r = '0;
            r.status = st;
            if (st == whp_pkg::ST_OK) begin
                r.channel_count = channels;
                r.samp_rate = rate;
                r.byte_rate = byte_rate;
                r.sample_bits = bits;
                r.payload_size = decl_size;
                r.payload_offset = header_bytes;
            end
            pending_reports.push_back(r);
            if (last) restart();
            else phase = whp_pkg::PH_DROP;
        endfunction

        function void compare_field(string name, logic [32:0] want, logic [32:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        // one result word against the oldest report owed
        function void check_report(whp_pkg::t_result got);
            whp_pkg::t_result want;
            if (pending_reports.size() == 0) begin
                errors++;
                $display("%0t: result with none outstanding, status %0d", $time, got.status);
                return;
            end
            want = pending_reports.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("channel_count", want.channel_count, got.channel_count);
            compare_field("samp_rate", want.samp_rate, got.samp_rate);
            compare_field("byte_rate", want.byte_rate, got.byte_rate);
            compare_field("sample_bits", want.sample_bits, got.sample_bits);
            compare_field("payload_size", want.payload_size, got.payload_size);
            compare_field("payload_offset", want.payload_offset, got.payload_offset);
        endfunction
    endclass

    header_scoreboard hdr_sb = new();

    logic [7:0]       frame[$];
    int               bytes_sent = 0;
    int               cycles = 0;
    bit               tx_calm = 1'b0;
    bit               rx_calm = 1'b0;
    int               rx_wait = 0;
    bit               pressure_go = 1'b0;
    logic             hold_on = 1'b0;
    whp_pkg::t_result seen_report;

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // result side: take, check, then draw the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_report.status = whp_pkg::t_status'(o_status);
            seen_report.channel_count = o_channel_count;
            seen_report.samp_rate = o_samp_rate;
            seen_report.byte_rate = o_byte_rate;
            seen_report.sample_bits = o_sample_bits;
            seen_report.payload_size = o_payload_size;
            seen_report.payload_offset = o_payload_offset;
            hdr_sb.check_report(seen_report);
            if ($urandom_range(0, 5) == 0) rx_calm = !rx_calm;
            rx_wait = rx_calm ? 0 : $urandom_range(0, 10);
        end else if (o_out_valid === 1'b1 && rx_wait != 0) begin
            rx_wait--;
        end
        i_out_stall <= hold_on || (rx_wait != 0);
    end

    // long receiver hold so the block backs up into its input
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // little-endian field onto the file being built
    task automatic add_word(logic [31:0] v, int n);
        for (int i = 0; i < n; i++) frame.push_back(v[8*i +: 8]);
    endtask

    task automatic cut_frame(int len);
        while (frame.size() > len) void'(frame.pop_back());
    endtask

    function automatic logic [31:0] field_value(int fill);
        case (fill)
            1: return '0;
            2: return '1;
            default: begin
                if ($urandom_range(0, 7) == 0) return '0;
                if ($urandom_range(0, 7) == 0) return '1;
                return $urandom;
            end
        endcase
    endfunction

    // riff/wave file, optional junk chunk, fmt chunk of the given format code, data chunk
    task automatic build_wav(bit with_junk, logic [31:0] junk_size, logic [31:0] fmt_size,
                             logic [31:0] fmt_code, logic [31:0] data_tag,
                             logic [31:0] decl_size, int data_n, int fill);
        logic [32:0] pad;
        int          n;
        add_word(whp_pkg::TAG_RIFF, 4);
        add_word($urandom, 4);
        add_word(whp_pkg::TAG_WAVE, 4);
        if (with_junk) begin
            add_word(whp_pkg::TAG_JUNK, 4);
            add_word(junk_size, 4);
            pad = {1'b0, junk_size} + junk_size[0];
            n = (pad > 16) ? $urandom_range(0, 6) : int'(pad);
            repeat (n) add_word($urandom, 1);
        end
        add_word(whp_pkg::TAG_FMT, 4);
        add_word(fmt_size, 4);
        add_word(fmt_code, 2);
        add_word(field_value(fill), 2);
        add_word(field_value(fill), 4);
        add_word(field_value(fill), 4);
        add_word($urandom, 2);
        add_word(field_value(fill), 2);
        add_word(data_tag, 4);
        add_word(decl_size, 4);
        repeat (data_n) add_word($urandom, 1);
    endtask

    // one input word, after a drawn gap
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_value <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        hdr_sb.take_byte(b, last);
        bytes_sent++;
    endtask

    // whole file, last flag on its final byte
    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
        frame.delete();
    endtask

    initial begin : stimulus
        logic [31:0] jsize;
        logic [31:0] dsize;
        int          pick;
        int          dn;
        int          len;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_byte_value <= '0;
        i_last_byte <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // file of one byte, and a tag cut short
        add_word(whp_pkg::TAG_RIFF, 1);
        send_frame();
        add_word(whp_pkg::TAG_RIFF, 2);
        send_frame();
        // bad riff tag judged on the last byte
        add_word(whp_pkg::TAG_RIFF ^ 32'h0100_0000, 4);
        send_frame();
        // bad riff tag, rest of the file dropped
        add_word(whp_pkg::TAG_RIFF ^ 32'h0000_0020, 4);
        add_word($urandom, 3);
        send_frame();
        // bad wave tag
        build_wav(1'b0, 0, whp_pkg::FMT_CHUNK_SIZE, whp_pkg::FMT_PCM, whp_pkg::TAG_DATA,
                  0, 0, 0);
        frame[9] ^= 8'h40;
        send_frame();
        // unknown chunk in place of junk or fmt
        build_wav(1'b0, 0, whp_pkg::FMT_CHUNK_SIZE, whp_pkg::FMT_PCM, whp_pkg::TAG_DATA,
                  0, 0, 0);
        frame[14] ^= 8'h01;
        send_frame();
        // bad fmt tag after an odd junk chunk
        build_wav(1'b1, 3, whp_pkg::FMT_CHUNK_SIZE, whp_pkg::FMT_PCM, whp_pkg::TAG_DATA,
                  0, 0, 0);
        frame[26] ^= 8'h80;
        send_frame();
        // fmt size, format code and data tag errors
        build_wav(1'b0, 0, 32'd18, whp_pkg::FMT_PCM, whp_pkg::TAG_DATA, 0, 0, 0);
        send_frame();
        build_wav(1'b0, 0, whp_pkg::FMT_CHUNK_SIZE, 32'd3, whp_pkg::TAG_DATA, 0, 0, 0);
        send_frame();
        build_wav(1'b0, 0, whp_pkg::FMT_CHUNK_SIZE, whp_pkg::FMT_PCM,
                  whp_pkg::TAG_DATA ^ 32'h0000_2000, 4, 4, 0);
        send_frame();
        // data tag error on the final byte
        build_wav(1'b0, 0, whp_pkg::FMT_CHUNK_SIZE, whp_pkg::FMT_PCM,
                  whp_pkg::TAG_DATA ^ 32'h2000_0000, 0, 0, 0);
        cut_frame(40);
        send_frame();
        // clean files: empty junk, all-ones and all-zero fields, odd junk
        build_wav(1'b1, 0, whp_pkg::FMT_CHUNK_SIZE, whp_pkg::FMT_PCM, whp_pkg::TAG_DATA,
                  0, 0, 2);
        send_frame();
        build_wav(1'b0, 0, whp_pkg::FMT_CHUNK_SIZE, whp_pkg::FMT_PCM, whp_pkg::TAG_DATA,
                  7, 7, 1);
        send_frame();
        build_wav(1'b1, 5, whp_pkg::FMT_CHUNK_SIZE, whp_pkg::FMT_PCM, whp_pkg::TAG_DATA,
                  9, 9, 0);
        send_frame();
        // extra data midway and on the last byte, short data
        build_wav(1'b0, 0, whp_pkg::FMT_CHUNK_SIZE, whp_pkg::FMT_PCM, whp_pkg::TAG_DATA,
                  3, 6, 0);
        send_frame();
        build_wav(1'b0, 0, whp_pkg::FMT_CHUNK_SIZE, whp_pkg::FMT_PCM, whp_pkg::TAG_DATA,
                  3, 4, 0);
        send_frame();
        build_wav(1'b0, 0, whp_pkg::FMT_CHUNK_SIZE, whp_pkg::FMT_PCM, whp_pkg::TAG_DATA,
                  5, 2, 0);
        send_frame();
        // largest junk size must not wrap its padding to zero
        build_wav(1'b1, 32'hFFFF_FFFF, whp_pkg::FMT_CHUNK_SIZE, whp_pkg::FMT_PCM,
                  whp_pkg::TAG_DATA, 0, 0, 0);
        send_frame();
        // end inside the data size field
        build_wav(1'b0, 0, whp_pkg::FMT_CHUNK_SIZE, whp_pkg::FMT_PCM, whp_pkg::TAG_DATA,
                  0, 0, 0);
        cut_frame(42);
        send_frame();

        // random files: noise, well formed and damaged files with random content
        while (bytes_sent < 1150) begin
            if (!pressure_go && bytes_sent > 500) begin
                // short bad files back to back while the receiver holds off
                pressure_go = 1'b1;
                tx_calm = 1'b1;
                repeat (12) begin
                    add_word($urandom, 4);
                    send_frame();
                end
                tx_calm = 1'b0;
            end
            if ($urandom_range(0, 5) == 0) tx_calm = !tx_calm;
            if ($urandom_range(0, 3) == 0) begin
                // noise, sometimes after a good riff tag
                if ($urandom_range(0, 1) == 0) add_word(whp_pkg::TAG_RIFF, 4);
                repeat ($urandom_range(1, 12)) add_word($urandom, 1);
            end else begin
                pick = $urandom_range(0, 9);
                jsize = (pick < 8) ? $urandom_range(0, 9) : (pick == 8 ? $urandom : '1);
                pick = $urandom_range(0, 9);
                dsize = (pick < 8) ? $urandom_range(0, 24) : (pick == 8 ? $urandom : '1);
                dn = (dsize > 40) ? $urandom_range(0, 8) : int'(dsize);
                build_wav($urandom_range(0, 2) == 0, jsize, whp_pkg::FMT_CHUNK_SIZE,
                          whp_pkg::FMT_PCM, whp_pkg::TAG_DATA, dsize, dn,
                          ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
                // damage a header bit, cut the file, or add bytes past the data
                pick = $urandom_range(0, 19);
                len = (frame.size() < 44) ? frame.size() : 44;
                if (pick < 4) begin
                    frame[$urandom_range(0, len - 1)] ^= 8'h01 << $urandom_range(0, 7);
                end else if (pick < 6) begin
                    cut_frame($urandom_range(1, frame.size()));
                end else if (pick < 9) begin
                    repeat ($urandom_range(1, 4)) add_word($urandom, 1);
                end
            end
            send_frame();
        end
        i_in_valid <= 1'b0;

        // drain outstanding reports, then watch for strays
        while (hdr_sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (hdr_sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
